/* rtl/nsq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsq_pkg
// Shared widths, constants and the axis record type for the nine-slice quad generator.
// ----------------------------------------------------------------------------
package nsq_pkg;

  localparam int COORD_W       = 20;
  localparam int DIM_W         = 13;
  localparam int CUT_W         = 18;
  localparam int TINT_W        = 24;
  localparam int TAG_W         = 48;
  localparam int UV_W          = 17;
  localparam int IMAGE_DIM_MAX = 4096;
  localparam int UV_FRAC_BITS  = 16;

  // quotient bits resolved per divider stage
  localparam int UV_DIV_STEP   = 4;

  // source edges in Q.4: up to IMAGE_DIM_MAX*16
  localparam int SRC_W  = 21;
  // signed working width for destination math
  localparam int WIDE_W = 23;

  typedef struct packed {
    logic signed [COORD_W-1:0] d0;
    logic signed [COORD_W-1:0] d1;
    logic signed [COORD_W-1:0] d2;
    logic signed [COORD_W-1:0] d3;
    logic [SRC_W-1:0]          s1;
    logic [SRC_W-1:0]          s2;
    logic [SRC_W-1:0]          s3;
  } axis_t;

endpackage

/* rtl/nsq_axis.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsq_axis
// Three-stage pipeline for one axis: clamp dimension and cuts, size the
// corners, place the four destination edges.
// ----------------------------------------------------------------------------
module nsq_axis
  import nsq_pkg::*;
#(
  parameter int DIM_MAX = IMAGE_DIM_MAX
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic signed [COORD_W-1:0] bmin,
  input  logic signed [COORD_W-1:0] bmax,
  input  logic [DIM_W-1:0]          dim_in,
  input  logic signed [CUT_W-1:0]   c0,
  input  logic signed [CUT_W-1:0]   c1,
  output logic [DIM_W+3:0]          dim_out,
  output axis_t                     ax
);

  localparam int DW = DIM_W + 4;

  logic [DW-1:0]             dim_c;
  logic signed [WIDE_W-1:0]  full_w, lo_w, hi_w, c0_w, c1_w, span_w, e0_w, e1_w, rem_w;
  logic signed [WIDE_W-1:0]  full1, lo1, hi1, span1;
  logic signed [WIDE_W-1:0]  full2, lo2, hi2, e0_2, e1_2;
  logic signed [COORD_W-1:0] bmin1, bmax1, bmin2, bmax2;
  logic [DW-1:0]             dim1, dim2;

  always_comb begin
    if (dim_in == '0) begin
      dim_c = DW'(1);
    end else if (DW'(dim_in) > DW'(DIM_MAX)) begin
      dim_c = DW'(DIM_MAX);
    end else begin
      dim_c = DW'(dim_in);
    end
    full_w = WIDE_W'(dim_c) <<< 4;
    c0_w   = WIDE_W'(c0);
    c1_w   = WIDE_W'(c1);
    lo_w   = (c0_w < 0) ? '0 : ((c0_w > full_w) ? full_w : c0_w);
    hi_w   = (c1_w < lo_w) ? lo_w : ((c1_w > full_w) ? full_w : c1_w);
    span_w = WIDE_W'(bmax) - WIDE_W'(bmin);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      full1 <= full_w;
      lo1   <= lo_w;
      hi1   <= hi_w;
      span1 <= span_w;
      bmin1 <= bmin;
      bmax1 <= bmax;
      dim1  <= dim_c;
    end
  end

  always_comb begin
    e0_w  = (lo1 < span1) ? lo1 : span1;
    rem_w = span1 - e0_w;
    if (rem_w < 0) rem_w = '0;
    e1_w  = ((full1 - hi1) < rem_w) ? (full1 - hi1) : rem_w;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      full2 <= full1;
      lo2   <= lo1;
      hi2   <= hi1;
      e0_2  <= e0_w;
      e1_2  <= e1_w;
      bmin2 <= bmin1;
      bmax2 <= bmax1;
      dim2  <= dim1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ax.d0   <= bmin2;
      ax.d1   <= COORD_W'(WIDE_W'(bmin2) + e0_2);
      ax.d2   <= COORD_W'(WIDE_W'(bmax2) - e1_2);
      ax.d3   <= bmax2;
      ax.s1   <= SRC_W'(lo2);
      ax.s2   <= SRC_W'(hi2);
      ax.s3   <= SRC_W'(full2);
      dim_out <= dim2;
    end
  end

endmodule

/* rtl/nsq_uv_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsq_uv_div
// Pipelined restoring divider: floor((s << FRAC) / (dim*16)), UV_DIV_STEP
// quotient bits per stage.
// ----------------------------------------------------------------------------
module nsq_uv_div
  import nsq_pkg::*;
#(
  parameter int FRAC  = UV_FRAC_BITS
) (
  input  logic              clk,
  input  logic              en,
  input  logic [SRC_W-1:0]  s,
  input  logic [DIM_W+3:0]  dim,
  output logic [UV_W-1:0]   uv
);

  localparam int QB     = FRAC + 1;
  localparam int BPS    = UV_DIV_STEP;
  localparam int NST    = (QB + BPS - 1) / BPS;
  localparam int DV_W   = DIM_W + 8;
  localparam int R_W    = DV_W + 1;

  logic [R_W-1:0]   rem [NST+1];
  logic [QB-1:0]    q   [NST+1];
  logic [DV_W-1:0]  dv  [NST+1];

  // s <= dim*16, so the quotient fits QB bits and the first partial
  // remainder, s itself, never exceeds the divisor.
  assign rem[0] = '0;
  assign q[0]   = '0;
  assign dv[0]  = DV_W'(dim) << 4;

  logic [QB+SRC_W-1:0] num0;
  logic [QB+SRC_W-1:0] num [NST+1];
  assign num0   = (QB+SRC_W)'(s) << FRAC;
  assign num[0] = num0;

  for (genvar g = 0; g < NST; g++) begin : g_st
    logic [R_W-1:0]        r_c;
    logic [QB-1:0]         q_c;
    logic [QB+SRC_W-1:0]   n_c;
    localparam int HI = QB - 1 - g * BPS;
    localparam int NB = (HI + 1 < BPS) ? HI + 1 : BPS;
    always_comb begin
      r_c = rem[g];
      q_c = q[g];
      n_c = num[g];
      for (int b = 0; b < NB; b++) begin
        if (g == 0 && b == 0) begin
          r_c = R_W'(n_c >> (HI - b));
        end else begin
          r_c = {r_c[R_W-2:0], n_c[HI-b]};
        end
        if (r_c >= R_W'(dv[g])) begin
          r_c = r_c - R_W'(dv[g]);
          q_c[HI-b] = 1'b1;
        end
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        rem[g+1] <= r_c;
        q[g+1]   <= q_c;
        num[g+1] <= n_c;
        dv[g+1]  <= dv[g];
      end
    end
  end

  assign uv = UV_W'(q[NST]);

endmodule

/* rtl/nsq_emit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsq_emit
// Holds one item's grid and walks its nine cells in row-major order,
// presenting each non-degenerate cell; flags the final one.
// ----------------------------------------------------------------------------
module nsq_emit
  import nsq_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  axis_t              ax,
  input  axis_t              ay,
  input  logic [UV_W-1:0]    ux [4],
  input  logic [UV_W-1:0]    vy [4],
  input  logic [TINT_W-1:0]  tint,
  input  logic [TAG_W-1:0]   tag,
  output logic               out_valid,
  input  logic               out_take,
  output logic signed [COORD_W-1:0] qx0, qy0, qx1, qy1,
  output logic [UV_W-1:0]    qu0, qv0, qu1, qv1,
  output logic [TINT_W-1:0]  qtint,
  output logic [TAG_W-1:0]   qtag,
  output logic               qlast
);

  logic                      busy;
  logic [8:0]                pend;
  logic signed [COORD_W-1:0] dx [4];
  logic signed [COORD_W-1:0] dy [4];
  logic [UV_W-1:0]           uu [4];
  logic [UV_W-1:0]           vv [4];
  logic [TINT_W-1:0]         tint_r;
  logic [TAG_W-1:0]          tag_r;
  logic [8:0]                live;
  logic [8:0]                pend_next;
  logic [3:0]                idx;
  logic [1:0]                row, col;

  function automatic logic signed [COORD_W-1:0] ax_d(input int i);
    unique case (i)
      0: ax_d = ax.d0;
      1: ax_d = ax.d1;
      2: ax_d = ax.d2;
      default: ax_d = ax.d3;
    endcase
  endfunction

  function automatic logic signed [COORD_W-1:0] ay_d(input int i);
    unique case (i)
      0: ay_d = ay.d0;
      1: ay_d = ay.d1;
      2: ay_d = ay.d2;
      default: ay_d = ay.d3;
    endcase
  endfunction

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        live[r*3+c] = (ax_d(c+1) > ax_d(c)) && (ay_d(r+1) > ay_d(r));
      end
    end
  end

  always_comb begin
    idx = 4'd0;
    for (int i = 8; i >= 0; i--) begin
      if (pend[i]) idx = 4'(i);
    end
    pend_next = pend;
    pend_next[idx] = 1'b0;
    row = (idx >= 4'd6) ? 2'd2 : ((idx >= 4'd3) ? 2'd1 : 2'd0);
    col = 2'(idx - 4'(row) * 4'd3);
  end

  assign out_valid = busy;
  assign in_ready  = !busy || (out_take && pend_next == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pend <= '0;
    end else if (in_ready) begin
      busy <= in_valid && (live != '0);
      pend <= live;
    end else if (out_take) begin
      pend <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      dx[0] <= ax.d0; dx[1] <= ax.d1; dx[2] <= ax.d2; dx[3] <= ax.d3;
      dy[0] <= ay.d0; dy[1] <= ay.d1; dy[2] <= ay.d2; dy[3] <= ay.d3;
      uu     <= ux;
      vv     <= vy;
      tint_r <= tint;
      tag_r  <= tag;
    end
  end

  assign qx0   = dx[col];
  assign qx1   = dx[col+2'd1];
  assign qy0   = dy[row];
  assign qy1   = dy[row+2'd1];
  assign qu0   = uu[col];
  assign qu1   = uu[col+2'd1];
  assign qv0   = vv[row];
  assign qv1   = vv[row+2'd1];
  assign qtint = tint_r;
  assign qtag  = tag_r;
  assign qlast = (pend_next == '0);

endmodule

/* rtl/nine_slice_quad_generator_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nine_slice_quad_generator_top
// Nine-slice quad generator: clamps cuts, sizes corners, divides texture
// coordinates in a pipeline and emits up to nine quads per item.
//
//   channel | handshake          | payload
//   in      | in_valid/in_stall  | box, image size, cuts, tint, tag
//   out     | out_valid/out_stall| quad corners, uv, tint, tag, last_quad
//
// Nine register stages lie between input and first quad: the axis pipeline
// (3), the divider stages (ceil((UV_FRAC_BITS+1)/4), 5 by default) and the
// emitter register (1).
// An item occupies the output for one cycle per live quad (1 to 9) while out_stall
// is low; an item with no live quad is taken by the emitter and yields no quad.
// The pipeline advances only when the emitter can take a new item.
// Reset clears valid bits only.
// ----------------------------------------------------------------------------
module nine_slice_quad_generator_top
  import nsq_pkg::*;
#(
  parameter int IMG_DIM_MAX = IMAGE_DIM_MAX,
  parameter int UV_FRAC     = UV_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [COORD_W-1:0] box_min_x,
  input  logic signed [COORD_W-1:0] box_min_y,
  input  logic signed [COORD_W-1:0] box_max_x,
  input  logic signed [COORD_W-1:0] box_max_y,
  input  logic [DIM_W-1:0]          image_width,
  input  logic [DIM_W-1:0]          image_height,
  input  logic signed [CUT_W-1:0]   cut_left,
  input  logic signed [CUT_W-1:0]   cut_top,
  input  logic signed [CUT_W-1:0]   cut_right,
  input  logic signed [CUT_W-1:0]   cut_bottom,
  input  logic [TINT_W-1:0]         tint_rgb,
  input  logic [TAG_W-1:0]          draw_tag,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] dst_min_x,
  output logic signed [COORD_W-1:0] dst_min_y,
  output logic signed [COORD_W-1:0] dst_max_x,
  output logic signed [COORD_W-1:0] dst_max_y,
  output logic [UV_W-1:0]           tex_u_min,
  output logic [UV_W-1:0]           tex_v_min,
  output logic [UV_W-1:0]           tex_u_max,
  output logic [UV_W-1:0]           tex_v_max,
  output logic [TINT_W-1:0]         quad_tint,
  output logic [TAG_W-1:0]          quad_tag,
  output logic                      last_quad
);

  localparam int AX_ST = 3;
  localparam int DV_ST = (UV_FRAC + 1 + UV_DIV_STEP - 1) / UV_DIV_STEP;
  localparam int PW    = TINT_W + TAG_W + 2 * $bits(axis_t);

  logic                 en;
  logic                 em_ready;
  logic [AX_ST-1:0]     v_ax;
  logic [AX_ST-1:0]     v_ax_next;
  logic [TINT_W-1:0]    tint_p [AX_ST];
  logic [TAG_W-1:0]     tag_p  [AX_ST];
  axis_t                ax, ay;
  logic [DIM_W+3:0]     dimx, dimy;
  logic [PW-1:0]        pay_in;
  logic [PW-1:0]        pay_p [DV_ST];
  logic [UV_W-1:0]      ux [4];
  logic [UV_W-1:0]      vy [4];
  logic [SRC_W-1:0]     sx [4];
  logic [SRC_W-1:0]     sy [4];
  axis_t                ax_o, ay_o;
  logic                 v_o;
  logic [TINT_W-1:0]    tint_o;
  logic [TAG_W-1:0]     tag_o;
  logic [DV_ST-1:0]     v_dv;

  assign en       = em_ready;
  assign in_stall = !en;

  always_comb begin
    v_ax_next = {v_ax[AX_ST-2:0], in_valid};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_ax <= '0;
    end else if (en) begin
      v_ax <= v_ax_next;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      tint_p[0] <= tint_rgb;
      tag_p[0]  <= draw_tag;
      for (int i = 1; i < AX_ST; i++) begin
        tint_p[i] <= tint_p[i-1];
        tag_p[i]  <= tag_p[i-1];
      end
    end
  end

  nsq_axis #(.DIM_MAX(IMG_DIM_MAX)) u_ax (
    .clk(clk), .en(en), .bmin(box_min_x), .bmax(box_max_x), .dim_in(image_width),
    .c0(cut_left), .c1(cut_right), .dim_out(dimx), .ax(ax)
  );

  nsq_axis #(.DIM_MAX(IMG_DIM_MAX)) u_ay (
    .clk(clk), .en(en), .bmin(box_min_y), .bmax(box_max_y), .dim_in(image_height),
    .c0(cut_top), .c1(cut_bottom), .dim_out(dimy), .ax(ay)
  );

  assign pay_in = {tint_p[AX_ST-1], tag_p[AX_ST-1], ax, ay};
  assign sx[0] = '0; assign sx[1] = ax.s1; assign sx[2] = ax.s2; assign sx[3] = ax.s3;
  assign sy[0] = '0; assign sy[1] = ay.s1; assign sy[2] = ay.s2; assign sy[3] = ay.s3;

  for (genvar k = 0; k < 4; k++) begin : g_div
    nsq_uv_div #(.FRAC(UV_FRAC)) u_du (
      .clk(clk), .en(en), .s(sx[k]), .dim(dimx), .uv(ux[k])
    );
  end

  for (genvar k = 0; k < 4; k++) begin : g_dv
    nsq_uv_div #(.FRAC(UV_FRAC)) u_dv (
      .clk(clk), .en(en), .s(sy[k]), .dim(dimy), .uv(vy[k])
    );
  end

  // payload and valid bits follow the divider stages
  always_ff @(posedge clk) begin
    if (en) begin
      pay_p[0] <= pay_in;
      for (int i = 1; i < DV_ST; i++) begin
        pay_p[i] <= pay_p[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_dv <= '0;
    end else if (en) begin
      v_dv <= {v_dv[DV_ST-2:0], v_ax[AX_ST-1]};
    end
  end

  assign v_o = v_dv[DV_ST-1];
  assign {tint_o, tag_o, ax_o, ay_o} = pay_p[DV_ST-1];

  nsq_emit u_em (
    .clk(clk), .rst(rst), .in_valid(v_o), .in_ready(em_ready),
    .ax(ax_o), .ay(ay_o), .ux(ux), .vy(vy), .tint(tint_o), .tag(tag_o),
    .out_valid(out_valid), .out_take(!out_stall),
    .qx0(dst_min_x), .qy0(dst_min_y), .qx1(dst_max_x), .qy1(dst_max_y),
    .qu0(tex_u_min), .qv0(tex_v_min), .qu1(tex_u_max), .qv1(tex_v_max),
    .qtint(quad_tint), .qtag(quad_tag), .qlast(last_quad)
  );

endmodule

/* sim/nine_slice_quad_generator_top_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nine_slice_quad_generator_top_tb
// Drives boxes, image sizes and slice cuts into the quad generator, predicts
// the nine-slice quads of each item and checks every emitted quad in order,
// under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module nine_slice_quad_generator_top_tb;
  import nsq_pkg::*;

  typedef struct {
    logic signed [COORD_W-1:0] x0, y0, x1, y1;
    logic [UV_W-1:0]           u0, v0, u1, v1;
    logic [TINT_W-1:0]         tint;
    logic [TAG_W-1:0]          tag;
    logic                      last;
  } quad_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [COORD_W-1:0] box_min_x = '0, box_min_y = '0, box_max_x = '0, box_max_y = '0;
  logic [DIM_W-1:0] image_width = '0, image_height = '0;
  logic signed [CUT_W-1:0] cut_left = '0, cut_top = '0, cut_right = '0, cut_bottom = '0;
  logic [TINT_W-1:0] tint_rgb = '0;
  logic [TAG_W-1:0] draw_tag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [COORD_W-1:0] dst_min_x, dst_min_y, dst_max_x, dst_max_y;
  logic [UV_W-1:0] tex_u_min, tex_v_min, tex_u_max, tex_v_max;
  logic [TINT_W-1:0] quad_tint;
  logic [TAG_W-1:0] quad_tag;
  logic last_quad;

  quad_t pending_quads[$];
  int errors = 0;
  int cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  nine_slice_quad_generator_top dut (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("[nine_slice_quad_generator_top] ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  function automatic longint clamp_size(logic [DIM_W-1:0] d);
    longint v;
    v = d;
    if (v == 0) v = 1;
    if (v > IMAGE_DIM_MAX) v = IMAGE_DIM_MAX;
    return v;
  endfunction

  function automatic logic [UV_W-1:0] norm_uv(longint s, longint dim);
    longint q;
    q = (s << UV_FRAC_BITS) / (dim << 4);
    return q[UV_W-1:0];
  endfunction

  task automatic slice_axis(input longint bmin, bmax, c0, c1, full,
                            output longint src[4], output longint dst[4]);
    longint lo, hi, span, e0, e1, t;
    lo = c0 < 0 ? 0 : c0;
    if (lo > full) lo = full;
    hi = c1 < lo ? lo : c1;
    if (hi > full) hi = full;
    span = bmax - bmin;
    e0 = lo < span ? lo : span;
    t = span - e0;
    if (t < 0) t = 0;
    e1 = (full - hi) < t ? (full - hi) : t;
    src = '{0, lo, hi, full};
    dst = '{bmin, bmin + e0, bmax - e1, bmax};
  endtask

  task automatic predict_quads();
    longint sx[4], sy[4], dx[4], dy[4];
    longint w, h;
    quad_t q;
    int n;
    w = clamp_size(image_width);
    h = clamp_size(image_height);
    slice_axis(box_min_x, box_max_x, cut_left, cut_right, w * 16, sx, dx);
    slice_axis(box_min_y, box_max_y, cut_top, cut_bottom, h * 16, sy, dy);
    n = 0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (dx[c+1] <= dx[c] || dy[r+1] <= dy[r]) continue;
        q.x0 = COORD_W'(dx[c]); q.y0 = COORD_W'(dy[r]);
        q.x1 = COORD_W'(dx[c+1]); q.y1 = COORD_W'(dy[r+1]);
        q.u0 = norm_uv(sx[c], w); q.v0 = norm_uv(sy[r], h);
        q.u1 = norm_uv(sx[c+1], w); q.v1 = norm_uv(sy[r+1], h);
        q.tint = tint_rgb; q.tag = draw_tag; q.last = 1'b0;
        pending_quads.insert(pending_quads.size(), q);
        n++;
      end
    end
    if (n > 0) pending_quads[$].last = 1'b1;
  endtask

  always @(posedge clk) begin
    quad_t e;
    if (!rst && out_valid && !out_stall) begin
      if (pending_quads.size() == 0) begin
        $error("unexpected quad");
        errors++;
      end else begin
        e = pending_quads.pop_front();
        if (dst_min_x !== e.x0) begin $error("dst_min_x exp %0d got %0d", e.x0, dst_min_x); errors++; end
        if (dst_min_y !== e.y0) begin $error("dst_min_y exp %0d got %0d", e.y0, dst_min_y); errors++; end
        if (dst_max_x !== e.x1) begin $error("dst_max_x exp %0d got %0d", e.x1, dst_max_x); errors++; end
        if (dst_max_y !== e.y1) begin $error("dst_max_y exp %0d got %0d", e.y1, dst_max_y); errors++; end
        if (tex_u_min !== e.u0) begin $error("tex_u_min exp %0d got %0d", e.u0, tex_u_min); errors++; end
        if (tex_v_min !== e.v0) begin $error("tex_v_min exp %0d got %0d", e.v0, tex_v_min); errors++; end
        if (tex_u_max !== e.u1) begin $error("tex_u_max exp %0d got %0d", e.u1, tex_u_max); errors++; end
        if (tex_v_max !== e.v1) begin $error("tex_v_max exp %0d got %0d", e.v1, tex_v_max); errors++; end
        if (quad_tint !== e.tint) begin $error("quad_tint exp %h got %h", e.tint, quad_tint); errors++; end
        if (quad_tag !== e.tag) begin $error("quad_tag exp %h got %h", e.tag, quad_tag); errors++; end
        if (last_quad !== e.last) begin $error("last_quad exp %0d got %0d", e.last, last_quad); errors++; end
      end
    end
  end

  // one item; fields already set by caller through the arguments
  task automatic send_item(input logic [COORD_W-1:0] bx0, by0, bx1, by1,
                           input logic [DIM_W-1:0] iw, ih,
                           input logic [CUT_W-1:0] cl, ct, cr, cb,
                           input logic [TINT_W-1:0] tint, input logic [TAG_W-1:0] tag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    box_min_x <= bx0; box_min_y <= by0; box_max_x <= bx1; box_max_y <= by1;
    image_width <= iw; image_height <= ih;
    cut_left <= cl; cut_top <= ct; cut_right <= cr; cut_bottom <= cb;
    tint_rgb <= tint; draw_tag <= tag;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_quads();
  endtask

  task automatic send_random(input bit wild);
    logic [COORD_W-1:0] x0, y0, x1, y1;
    logic [DIM_W-1:0] iw, ih;
    logic [CUT_W-1:0] cl, ct, cr, cb;
    iw = DIM_W'($urandom_range(1, 64)); ih = DIM_W'($urandom_range(1, 64));
    if ($urandom_range(9) == 0) iw = DIM_W'($urandom);
    if ($urandom_range(9) == 0) ih = DIM_W'($urandom);
    x0 = COORD_W'(int'($urandom_range(0, 8000)) - 4000);
    y0 = COORD_W'(int'($urandom_range(0, 8000)) - 4000);
    x1 = x0 + COORD_W'($urandom_range(0, 3000)); y1 = y0 + COORD_W'($urandom_range(0, 3000));
    cl = CUT_W'($urandom_range(0, iw * 8)); ct = CUT_W'($urandom_range(0, ih * 8));
    cr = cl + CUT_W'($urandom_range(0, iw * 16)); cb = ct + CUT_W'($urandom_range(0, ih * 16));
    if (wild) begin
      x0 = COORD_W'($urandom); y0 = COORD_W'($urandom);
      x1 = COORD_W'($urandom); y1 = COORD_W'($urandom);
      cl = CUT_W'($urandom); ct = CUT_W'($urandom); cr = CUT_W'($urandom); cb = CUT_W'($urandom);
    end
    send_item(x0, y0, x1, y1, iw, ih, cl, ct, cr, cb, TINT_W'($urandom),
              TAG_W'({$urandom, $urandom}));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_quads.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic test_directed();
    send_item(20'sd0, 20'sd0, 20'sd1600, 20'sd1600, 13'd32, 13'd32,
              18'sd64, 18'sd64, 18'sd448, 18'sd448, 24'hFFFFFF, '1);
    send_item(20'sd0, 20'sd0, 20'sd100, 20'sd100, 13'd32, 13'd32,
              18'sd160, 18'sd160, 18'sd352, 18'sd352, 24'h0, '0);
    send_item(20'sd100, 20'sd0, 20'sd50, 20'sd10, 13'd8, 13'd8,
              18'sd16, 18'sd16, 18'sd96, 18'sd96, 24'h123456, 48'h1);
    send_item(20'sd0, 20'sd0, 20'sd0, 20'sd100, 13'd8, 13'd8,
              18'sd16, 18'sd16, 18'sd96, 18'sd96, 24'h1, 48'h2);
    send_item(20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF, 13'd0, 13'd0,
              18'h20000, 18'h20000, 18'h1FFFF, 18'h1FFFF, 24'hA5A5A5, 48'h5A5A5A5A5A5A);
    send_item(20'h80000, 20'h80000, 20'h7FFFF, 20'h7FFFF, 13'h1FFF, 13'd4096,
              18'h1FFFF, 18'h1FFFF, 18'h20000, 18'h20000, 24'h5A5A5A, 48'hA5A5A5A5A5A5);
    send_item(-20'sd500, -20'sd500, 20'sd500, 20'sd500, 13'd4097, 13'd1,
              -18'sd5, 18'sd3, 18'sd0, 18'sd200, 24'h00FF00, 48'hFFFF0000FFFF);
    send_item(20'sd0, 20'sd0, 20'sd1000, 20'sd1000, 13'd16, 13'd16,
              18'sd0, 18'sd0, 18'sd256, 18'sd256, 24'h0000FF, 48'hDEAD);
    send_item(20'sd0, 20'sd0, 20'sd1000, 20'sd1000, 13'd16, 13'd16,
              18'sd100, 18'sd100, 18'sd50, 18'sd50, 24'hFF0000, 48'hBEEF);
    send_item(20'sd7, 20'sd3, 20'sd8, 20'sd4, 13'd3, 13'd7,
              18'sd1, 18'sd1, 18'sd47, 18'sd111, 24'h7F7F7F, 48'h800000000000);
  endtask

  task automatic test_random(input int idle, input int stall, input int count);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < count; i++) send_random($urandom_range(9) == 0);
    wait_drained();
  endtask

  task automatic test_pause_to_empty();
    send_random(1'b0);
    send_random(1'b0);
    wait_drained();
    send_random(1'b0);
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_random(0, 0, 40);
    test_random(85, 0, 30);
    test_random(0, 85, 30);
    test_random(24, 24, 40);
    test_pause_to_empty();
    recv_stall_pct = 0;
    send_idle_pct = 0;
    wait_drained();
    if (errors == 0 && pending_quads.size() == 0) begin
      $display("[nine_slice_quad_generator_top] OK");
    end else begin
      $display("[nine_slice_quad_generator_top] ERROR");
    end
    $finish;
  end

endmodule
